FILE: rtl/core/mlc_pkg.sv
// Shared types, constants and helpers for the motion light controller.
package mlc_pkg;

  // Tick counter width and configuration word width
  localparam int COUNT_WIDTH   = 17;
  localparam int CFG_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CMP_WIDTH     = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  // Register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MANUAL_HOLD = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MOTION_HOLD = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SETTLE      = 2'd2;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] MANUAL_HOLD_RST = CFG_WIDTH'(15 * 1000);
  localparam logic [CFG_WIDTH-1:0] MOTION_HOLD_RST = CFG_WIDTH'(3 * 1000);
  localparam logic [CFG_WIDTH-1:0] SETTLE_RST      = CFG_WIDTH'(700);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_t;

  // Controller state carried from tick to tick
  typedef struct packed {
    cnt_t ticks_since_manual;
    cnt_t ticks_since_motion;
    cnt_t ticks_since_pulse;
    logic light1_state;
    logic light2_state;
    logic motion_on_latched;
  } mlc_state_t;

  // Configuration values as seen by the tick logic
  typedef struct packed {
    cfg_t manual_hold_ms;
    cfg_t motion_hold_ms;
    cfg_t settle_ms;
  } mlc_cfg_t;

  // One result word
  typedef struct packed {
    logic pulse_light1;
    logic pulse_light2;
    logic light1_on;
    logic light2_on;
    logic motion_active;
    logic manual_event;
  } mlc_result_t;

  // Saturating increment of a tick counter
  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == {COUNT_WIDTH{1'b1}}) ? v : v + cnt_t'(1);
  endfunction

  // Counter strictly above a hold value
  function automatic logic cnt_above(input cnt_t cnt, input cfg_t hold);
    return CMP_WIDTH'(cnt) > CMP_WIDTH'(hold);
  endfunction

endpackage

FILE: rtl/core/mlc_if.sv
// Valid/ready channel interfaces for tick input and result words.
interface mlc_in_if;
  logic valid;
  logic ready;
  logic motion_detected;
  logic light1_sense;
  logic light2_sense;

  modport source (output valid, motion_detected, light1_sense, light2_sense, input ready);
  modport sink   (input valid, motion_detected, light1_sense, light2_sense, output ready);
endinterface

interface mlc_out_if;
  logic valid;
  logic ready;
  logic pulse_light1;
  logic pulse_light2;
  logic light1_on;
  logic light2_on;
  logic motion_active;
  logic manual_event;

  modport source (output valid, pulse_light1, pulse_light2, light1_on, light2_on,
                  motion_active, manual_event, input ready);
  modport sink   (input valid, pulse_light1, pulse_light2, light1_on, light2_on,
                  motion_active, manual_event, output ready);
endinterface

FILE: rtl/core/mlc_tick.sv
// Combinational next-state and result logic for one millisecond tick.
module mlc_tick (
  input  mlc_pkg::mlc_state_t  state,
  input  mlc_pkg::mlc_cfg_t    cfg,
  input  logic                 motion_detected,
  input  logic                 light1_sense,
  input  logic                 light2_sense,
  output mlc_pkg::mlc_state_t  state_nxt,
  output mlc_pkg::mlc_result_t result
);
  import mlc_pkg::*;

  cnt_t manual_inc;
  cnt_t motion_inc;
  cnt_t pulse_inc;
  logic may_pulse;
  logic accept_motion;
  logic p1;
  logic p2;
  logic latch_nxt;
  cnt_t motion_cnt;
  cnt_t pulse_cnt;
  logic sense_open;
  logic on1;
  logic on2;
  logic chg1;
  logic chg2;

  // Advance all counters
  assign manual_inc = sat_inc(state.ticks_since_manual);
  assign motion_inc = sat_inc(state.ticks_since_motion);
  assign pulse_inc  = sat_inc(state.ticks_since_pulse);

  assign may_pulse     = cnt_above(pulse_inc, cfg.settle_ms);
  assign accept_motion = cnt_above(manual_inc, cfg.manual_hold_ms);

  // Motion handling after the manual lockout: switch on when motion appears, off after hold time
  always_comb begin
    p1         = 1'b0;
    p2         = 1'b0;
    latch_nxt  = state.motion_on_latched;
    motion_cnt = motion_inc;
    if (accept_motion) begin
      if (motion_detected) begin
        if (!state.motion_on_latched && may_pulse) begin
          p1        = !state.light1_state;
          p2        = !state.light2_state;
          latch_nxt = 1'b1;
        end
        motion_cnt = '0;
      end else if (cnt_above(motion_inc, cfg.motion_hold_ms)) begin
        if (may_pulse) begin
          p1 = state.light1_state;
          p2 = state.light2_state;
        end
        latch_nxt = 1'b0;
      end
    end
  end

  // Restart settle window on any pulse
  assign pulse_cnt  = (p1 || p2) ? '0 : pulse_inc;
  assign sense_open = cnt_above(pulse_cnt, cfg.settle_ms);

  // Take manual switch changes once the sense lines have settled
  assign on1  = !light1_sense;
  assign on2  = !light2_sense;
  assign chg1 = sense_open && (on1 != state.light1_state);
  assign chg2 = sense_open && (on2 != state.light2_state);

  always_comb begin
    state_nxt.ticks_since_manual = (chg1 || chg2) ? '0 : manual_inc;
    state_nxt.ticks_since_motion = motion_cnt;
    state_nxt.ticks_since_pulse  = pulse_cnt;
    state_nxt.light1_state       = chg1 ? on1 : state.light1_state;
    state_nxt.light2_state       = chg2 ? on2 : state.light2_state;
    state_nxt.motion_on_latched  = latch_nxt;
  end

  // Assemble result word
  always_comb begin
    result.pulse_light1  = p1;
    result.pulse_light2  = p2;
    result.light1_on     = state_nxt.light1_state;
    result.light2_on     = state_nxt.light2_state;
    result.motion_active = accept_motion && motion_detected;
    result.manual_event  = chg1 || chg2;
  end

endmodule

FILE: rtl/core/motion_light_controller.sv
// Motion light controller: one result word per millisecond tick word.
// Each result word is registered, loaded as its tick word is accepted.
// Throughput: one word per cycle unless stalled; the output register frees on a take.
// Input ready drops only while the output register holds a word not yet taken.
// Reset (rst_n low, synchronous): counters and light states clear, registers take
// their default hold times, and the output register empties.
module motion_light_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  mlc_in_if.sink                            in_ch,
  mlc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [mlc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [mlc_pkg::CFG_WIDTH-1:0]     cfg_data
);
  import mlc_pkg::*;

  mlc_state_t  state_r;
  mlc_state_t  state_nxt;
  mlc_cfg_t    cfg_r;
  mlc_result_t result_nxt;
  mlc_result_t result_r;
  logic        out_valid_r;
  logic        in_take;

  // Accept whenever the output register is empty or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  mlc_tick u_tick (
    .state           (state_r),
    .cfg             (cfg_r),
    .motion_detected (in_ch.motion_detected),
    .light1_sense    (in_ch.light1_sense),
    .light2_sense    (in_ch.light2_sense),
    .state_nxt       (state_nxt),
    .result          (result_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.manual_hold_ms <= MANUAL_HOLD_RST;
      cfg_r.motion_hold_ms <= MOTION_HOLD_RST;
      cfg_r.settle_ms      <= SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MANUAL_HOLD: cfg_r.manual_hold_ms <= cfg_data;
        REG_MOTION_HOLD: cfg_r.motion_hold_ms <= cfg_data;
        REG_SETTLE:      cfg_r.settle_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pulse_light1  = result_r.pulse_light1;
  assign out_ch.pulse_light2  = result_r.pulse_light2;
  assign out_ch.light1_on     = result_r.light1_on;
  assign out_ch.light2_on     = result_r.light2_on;
  assign out_ch.motion_active = result_r.motion_active;
  assign out_ch.manual_event  = result_r.manual_event;

endmodule

FILE: rtl/core/mlc_checker.sv
// Port-level checks for the motion light controller, bound to the top level.
module mlc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pulse_light1,
  input logic pulse_light2,
  input logic manual_event
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // Hold stalled payload: pulse and manual event fields
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pulse_light1) && $stable(pulse_light2)
      && $stable(manual_event))
    else $error("result payload changed while stalled");

  // Every accepted tick word yields a result word next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick word produced no result word");

  // A pulse opens the settle window, so no manual event in the same word
  a_pulse_no_manual: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (pulse_light1 || pulse_light2) |-> !manual_event)
    else $error("manual event taken on a pulse tick");

  // Output register empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind motion_light_controller mlc_checker u_mlc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pulse_light1 (out_ch.pulse_light1),
  .pulse_light2 (out_ch.pulse_light2),
  .manual_event (out_ch.manual_event)
);

FILE: verif/tb.sv
// Testbench for motion_light_controller: directed and random tick words checked against a tick model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_PRINTS  = 20;
  localparam int LONG_HOLD   = 60;
  localparam int HOLD_AT     = 150;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic motion;
    logic sense1;
    logic sense2;
  } tick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  mlc_in_if  in_ch();
  mlc_out_if out_ch();

  motion_light_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Pending tick words and the result words they must produce
  tick_t       tick_queue[$];
  mlc_result_t predicted_words[$];
  tick_t       offered;

  // Tick model: hold times, counters and believed light states
  cfg_t hold_manual, hold_motion, hold_settle;
  cnt_t since_manual, since_motion, since_pulse;
  logic believed1, believed2, on_latched;

  // Physical lamps behind the switches, toggled by pulses and manual presses
  logic lamp1 = 1'b0;
  logic lamp2 = 1'b0;

  bit no_idle = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int long_left = 0;
  bit long_done = 1'b0;
  logic long_hold = 1'b0;
  int cycles = 0;
  int errors = 0;
  int words_seen = 0;
  int pulses_seen = 0;
  int manual_seen = 0;
  int motion_seen = 0;
  int reg_writes = 0;

  string field_names [6] = '{"pulse_light1", "pulse_light2", "light1_on", "light2_on",
                             "motion_active", "manual_event"};

  initial begin
    forever #5 clk = ~clk;
  end

  // Saturating tick counter step
  function automatic cnt_t bump(input cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Advance the model by one tick word and return the result word it yields
  function automatic mlc_result_t advance_tick(input tick_t t);
    mlc_result_t r;
    logic want1, want2, may_pulse;
    r = '0;
    want1 = !t.sense1;
    want2 = !t.sense2;
    since_manual = bump(since_manual);
    since_motion = bump(since_motion);
    since_pulse  = bump(since_pulse);
    may_pulse = since_pulse > hold_settle;
    // Act on motion only once the manual lockout has run out
    if (since_manual > hold_manual) begin
      if (t.motion) begin
        if (!on_latched && may_pulse) begin
          r.pulse_light1 = !believed1;
          r.pulse_light2 = !believed2;
          on_latched = 1'b1;
        end
        since_motion = '0;
        r.motion_active = 1'b1;
      end else if (since_motion > hold_motion) begin
        if (may_pulse) begin
          r.pulse_light1 = believed1;
          r.pulse_light2 = believed2;
        end
        on_latched = 1'b0;
      end
    end
    if (r.pulse_light1 || r.pulse_light2) since_pulse = '0;
    // Take sensed changes only outside the settle window
    if (since_pulse > hold_settle) begin
      if (want1 != believed1) begin
        believed1 = want1;
        r.manual_event = 1'b1;
      end
      if (want2 != believed2) begin
        believed2 = want2;
        r.manual_event = 1'b1;
      end
      if (r.manual_event) since_manual = '0;
    end
    r.light1_on = believed1;
    r.light2_on = believed2;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("tb: word %0d %s: got %b, expected %b", words_seen, what, got, want);
  endtask

  // Compare one taken result word with the oldest prediction
  task automatic check_word();
    mlc_result_t got, want;
    got = {out_ch.pulse_light1, out_ch.pulse_light2, out_ch.light1_on, out_ch.light2_on,
           out_ch.motion_active, out_ch.manual_event};
    words_seen++;
    if (predicted_words.size() == 0) begin
      report_mismatch("unexpected word", 1'b1, 1'b0);
    end else begin
      want = predicted_words.pop_front();
      for (int b = 0; b < 6; b++)
        if (got[5-b] !== want[5-b]) report_mismatch(field_names[b], got[5-b], want[5-b]);
    end
    // Toggle the lamps as the switches would
    if (got.pulse_light1 === 1'b1) lamp1 = !lamp1;
    if (got.pulse_light2 === 1'b1) lamp2 = !lamp2;
    pulses_seen += int'(got.pulse_light1 === 1'b1) + int'(got.pulse_light2 === 1'b1);
    manual_seen += int'(got.manual_event === 1'b1);
    motion_seen += int'(got.motion_active === 1'b1);
  endtask

  // Driver: offer queued tick words, with a random gap after each accepted word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_words.push_back(advance_tick(offered));
        gap_left = no_idle ? 0 : $urandom_range(0, 10);
      end
      // Hold a word that was not taken; otherwise idle or advance
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else if (tick_queue.size() > 0) begin
          offered = tick_queue.pop_front();
          in_ch.valid           <= 1'b1;
          in_ch.motion_detected <= offered.motion;
          in_ch.light1_sense    <= offered.sense1;
          in_ch.light2_sense    <= offered.sense2;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted apart from the random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      long_left = 0;
      long_hold <= 1'b0;
    end else begin
      if (long_left > 0) begin
        long_left--;
      end else if (!long_done && words_seen >= HOLD_AT) begin
        long_left = LONG_HOLD;
        long_done = 1'b1;
      end
      long_hold <= (long_left > 0);
    end
  end

  // Monitor: take result words, stalling at random and during the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_word();
        stall_left = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (long_hold) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_tick(input logic m, input logic s1, input logic s2);
    tick_t t;
    t.motion = m;
    t.sense1 = s1;
    t.sense2 = s2;
    tick_queue.push_back(t);
  endtask

  // Block until every queued word is taken and every result has come back
  task automatic wait_idle();
    while (tick_queue.size() != 0 || in_ch.valid || predicted_words.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input cfg_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MANUAL_HOLD: hold_manual = value;
      REG_MOTION_HOLD: hold_motion = value;
      REG_SETTLE:      hold_settle = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_holds(input cfg_t manual, input cfg_t motion, input cfg_t settle);
    wait_idle();
    write_reg(REG_MANUAL_HOLD, manual);
    write_reg(REG_MOTION_HOLD, motion);
    write_reg(REG_SETTLE, settle);
  endtask

  // Random ticks from a room: motion bursts, lamps that follow pulses, presses and noise
  task automatic run_room(input int count);
    tick_t t;
    logic moving;
    moving = $urandom_range(0, 1);
    for (int i = 0; i < count; i++) begin
      while (tick_queue.size() >= 2) @(negedge clk);
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) moving = !moving;
      if ($urandom_range(0, 11) == 0) lamp1 = !lamp1;
      if ($urandom_range(0, 11) == 0) lamp2 = !lamp2;
      t.motion = moving;
      t.sense1 = !lamp1;
      t.sense2 = !lamp2;
      if ($urandom_range(0, 24) == 0) t.sense1 = !t.sense1;
      if ($urandom_range(0, 24) == 0) t.sense2 = !t.sense2;
      if ($urandom_range(0, 19) == 0) {t.motion, t.sense1, t.sense2} = 3'($urandom_range(0, 7));
      tick_queue.push_back(t);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.motion_detected = 1'b0;
    in_ch.light1_sense = 1'b1;
    in_ch.light2_sense = 1'b1;
    out_ch.ready = 1'b0;
    hold_manual  = MANUAL_HOLD_RST;
    hold_motion  = MOTION_HOLD_RST;
    hold_settle  = SETTLE_RST;
    since_manual = '0;
    since_motion = '0;
    since_pulse  = '0;
    believed1    = 1'b0;
    believed2    = 1'b0;
    on_latched   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Default holds: motion locked out, sense lines inside the settle window
    push_tick(1'b1, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b1, 1'b0, 1'b1);

    // Out-of-range register write must change nothing
    wait_idle();
    write_reg(REG_UNUSED, 16'hFFFF);

    // Short holds: switch on, settle, sensed on, hold-off, retried switch-off
    set_holds(16'd0, 16'd2, 16'd1);
    push_tick(1'b1, 1'b1, 1'b1);
    push_tick(1'b1, 1'b1, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b1, 1'b1, 1'b1);

    // Manual press starts a lockout that masks motion
    set_holds(16'd3, 16'd2, 16'd0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b1);
    push_tick(1'b1, 1'b0, 1'b1);

    // Random rooms: all-zero holds first, then small random holds
    wait_idle();
    lamp1 = believed1;
    lamp2 = believed2;
    set_holds(16'd0, 16'd0, 16'd0);
    run_room(100);
    for (int p = 0; p < 3; p++) begin
      set_holds(cfg_t'($urandom_range(0, 8)), cfg_t'($urandom_range(0, 8)),
                cfg_t'($urandom_range(0, 8)));
      run_room(100);
    end

    // Settle both lights off before the full-scale holds
    set_holds(16'd1, 16'd1, 16'd1);
    for (int i = 0; i < 20; i++) push_tick(1'b0, 1'b1, 1'b1);

    // Full-scale holds: wide compares keep motion locked out and sense lines inside the settle window
    set_holds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_tick(1'b1, 1'b1, 1'b1);
    push_tick(1'b1, 1'b0, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b1, 1'b1, 1'b1);
    push_tick(1'b0, 1'b1, 1'b1);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("tb: %0d result words checked, %0d pulses, %0d manual events, %0d motion ticks",
             words_seen, pulses_seen, manual_seen, motion_seen);
    $display("tb: %0d register writes over default, zero, random and full-scale hold times",
             reg_writes);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: end the run as a failure when the cycle limit is reached
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/mlc_pkg.sv
rtl/core/mlc_if.sv
rtl/core/mlc_tick.sv
rtl/core/motion_light_controller.sv
rtl/core/mlc_checker.sv
verif/tb.sv
